>>> sv/tpsc_pkg.sv
// Shared types, constants and register codes for the thermal speed controller.
package tpsc_pkg;

   localparam int TEMP_W     = 8;
   localparam int SETPOINT_W = 12;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 8;
   localparam int STEP_W     = 10;
   localparam int SPEED_W    = 10;
   localparam int FMAX_W     = 16;
   localparam int FREQ_W     = 16;
   localparam int MEAS_W     = 13;
   localparam int ERR_W      = 14;
   localparam int CHG_W      = 9;
   localparam int HI_W       = 16;
   localparam int CLAMP_W    = 17;
   localparam int SPD_W      = 21;
   localparam int RES_W      = 16;
   localparam int FPROD_W    = 26;
   localparam int QUOT_W     = 17;
   localparam int REM_W      = 27;
   localparam int MUL_A_W    = 27;
   localparam int MUL_B_W    = 16;
   localparam int MUL_P_W    = 44;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int RECIP_SHIFT = 24;

   localparam logic [MEAS_W-1:0]  STALE_OFFSET = 13'd10;
   localparam logic [MUL_B_W-1:0] RECIP_MULT   = 16'd16777;
   localparam logic [MUL_B_W-1:0] FREQ_DIV     = 16'd1000;
   localparam logic [REM_W-1:0]   FREQ_DIV_REM = 27'd1000;

   localparam logic [SETPOINT_W-1:0] SETPOINT_RST    = 12'd850;
   localparam logic [GAIN_W-1:0]     GAIN_RST        = 16'd0;
   localparam logic [LIMIT_W-1:0]    STEP_LIMIT_RST  = 8'd1;
   localparam logic [STEP_W-1:0]     STEP_SIZE_RST   = 10'd1;
   localparam logic [SPEED_W-1:0]    SPEED_CEIL_RST  = 10'd1000;
   localparam logic [SPEED_W-1:0]    SPEED_FLOOR_RST = 10'd0;
   localparam logic [FMAX_W-1:0]     FMAX_RST        = 16'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT    = 3'd0,
      CSR_GAIN        = 3'd1,
      CSR_STEP_LIMIT  = 3'd2,
      CSR_STEP_SIZE   = 3'd3,
      CSR_SPEED_CEIL  = 3'd4,
      CSR_SPEED_FLOOR = 3'd5,
      CSR_FMAX        = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,
      S_CLAMP,
      S_DELTA,
      S_SPEED,
      S_FREQ,
      S_RECIP,
      S_BACK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temperature;
      logic              reading_stale;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_out;
      logic [FREQ_W-1:0]  freq_out;
      logic               at_setpoint;
   } rsp_type;

   typedef struct packed {
      logic [SETPOINT_W-1:0] setpoint;
      logic [GAIN_W-1:0]     gain;
      logic [LIMIT_W-1:0]    step_limit;
      logic [STEP_W-1:0]     step_size;
      logic [SPEED_W-1:0]    speed_ceil;
      logic [SPEED_W-1:0]    speed_floor;
      logic [FMAX_W-1:0]     fmax;
   } cfg_type;

endpackage

>>> sv/tpsc_mul.sv
// Shared signed-by-unsigned multiplier with registered product.
module tpsc_mul (
   input  logic                                 clock,
   input  logic signed [tpsc_pkg::MUL_A_W-1:0]  mul_a,
   input  logic        [tpsc_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [tpsc_pkg::MUL_P_W-1:0]  prod
);

   logic signed [tpsc_pkg::MUL_P_W-1:0] prod_in;
   logic signed [tpsc_pkg::MUL_P_W-1:0] prod_ff;
   logic signed [tpsc_pkg::MUL_B_W:0]   b_ext;

   assign b_ext   = signed'({1'b0, mul_b});
   assign prod_in = mul_a * b_ext;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> sv/tpsc_csr.sv
// Configuration register file for the thermal speed controller.
module tpsc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tpsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tpsc_pkg::CSR_DATA_W-1:0]    csr_data,
   output tpsc_pkg::cfg_type                  cfg
);

   tpsc_pkg::cfg_type cfg_ff;
   tpsc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tpsc_pkg::CSR_SETPOINT:    cfg_in.setpoint    = csr_data[tpsc_pkg::SETPOINT_W-1:0];
            tpsc_pkg::CSR_GAIN:        cfg_in.gain        = csr_data[tpsc_pkg::GAIN_W-1:0];
            tpsc_pkg::CSR_STEP_LIMIT:  cfg_in.step_limit  = csr_data[tpsc_pkg::LIMIT_W-1:0];
            tpsc_pkg::CSR_STEP_SIZE:   cfg_in.step_size   = csr_data[tpsc_pkg::STEP_W-1:0];
            tpsc_pkg::CSR_SPEED_CEIL:  cfg_in.speed_ceil  = csr_data[tpsc_pkg::SPEED_W-1:0];
            tpsc_pkg::CSR_SPEED_FLOOR: cfg_in.speed_floor = csr_data[tpsc_pkg::SPEED_W-1:0];
            tpsc_pkg::CSR_FMAX:        cfg_in.fmax        = csr_data[tpsc_pkg::FMAX_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint    <= tpsc_pkg::SETPOINT_RST;
         cfg_ff.gain        <= tpsc_pkg::GAIN_RST;
         cfg_ff.step_limit  <= tpsc_pkg::STEP_LIMIT_RST;
         cfg_ff.step_size   <= tpsc_pkg::STEP_SIZE_RST;
         cfg_ff.speed_ceil  <= tpsc_pkg::SPEED_CEIL_RST;
         cfg_ff.speed_floor <= tpsc_pkg::SPEED_FLOOR_RST;
         cfg_ff.fmax        <= tpsc_pkg::FMAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> sv/thermal_proportional_speed_controller.sv
// Thermal proportional speed controller top level: sequencer and datapath.
// Each accepted word is one control tick: the hottest temperature (or a stale flag) is
// compared with the setpoint, a proportional step with residue carry moves the speed
// request within the floor and ceiling limits (floor wins), and one result word returns
// the new speed, its frequency speed * fmax / 1000 (floor, saturated to 65535) and an
// at-setpoint flag. All products go one after another through a single 27 x 16
// multiplier, and the divide by 1000 is a reciprocal multiply plus one correction; a
// tick steps from ERR to DONE, skipping CLAMP, DELTA and SPEED at setpoint; the next
// word is accepted the cycle after the result is loaded into the output register, and a
// result still waiting there holds the sequencer in its last step. Configuration writes
// are always taken (csr_ready stays high); unknown indexes are dropped.
module thermal_proportional_speed_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tpsc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tpsc_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tpsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tpsc_pkg::CSR_DATA_W-1:0]  csr_data
);

   tpsc_pkg::cfg_type   cfg;
   tpsc_pkg::state_type state_ff;
   tpsc_pkg::state_type state_in;

   logic signed [tpsc_pkg::MUL_A_W-1:0] mul_a;
   logic        [tpsc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [tpsc_pkg::MUL_P_W-1:0] prod;

   logic load_req;
   logic upd_chg;
   logic upd_speed;
   logic load_p;
   logic load_q0;
   logic load_rsp;

   logic signed [tpsc_pkg::ERR_W-1:0]   err_ff;
   logic signed [tpsc_pkg::ERR_W-1:0]   err_in;
   logic                                hold_ff;
   logic                                hold_in;
   logic signed [tpsc_pkg::CHG_W-1:0]   chg_ff;
   logic signed [tpsc_pkg::CHG_W-1:0]   chg_in;
   logic                                carry_ff;
   logic                                carry_in;
   logic        [tpsc_pkg::RES_W-1:0]   residue_ff;
   logic        [tpsc_pkg::RES_W-1:0]   residue_in;
   logic        [tpsc_pkg::SPEED_W-1:0] speed_ff;
   logic        [tpsc_pkg::SPEED_W-1:0] speed_in;
   logic        [tpsc_pkg::FPROD_W-1:0] p_ff;
   logic        [tpsc_pkg::FPROD_W-1:0] p_in;
   logic        [tpsc_pkg::QUOT_W-1:0]  q0_ff;
   logic        [tpsc_pkg::QUOT_W-1:0]  q0_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   tpsc_pkg::rsp_type                   rsp_data_ff;
   tpsc_pkg::rsp_type                   rsp_data_in;

   logic        [tpsc_pkg::MEAS_W-1:0]  temp_ext;
   logic        [tpsc_pkg::MEAS_W-1:0]  temp_x10;
   logic        [tpsc_pkg::MEAS_W-1:0]  measured;
   logic        [tpsc_pkg::MEAS_W-1:0]  setpoint_ext;

   logic signed [tpsc_pkg::CLAMP_W-1:0] hi_ext;
   logic signed [tpsc_pkg::CLAMP_W-1:0] lim_pos;
   logic signed [tpsc_pkg::CLAMP_W-1:0] lim_neg;
   logic signed [tpsc_pkg::CLAMP_W-1:0] chg_wide;
   logic        [tpsc_pkg::RES_W:0]     res_sum;

   logic signed [tpsc_pkg::SPD_W-1:0]   spd_sum;
   logic signed [tpsc_pkg::SPD_W-1:0]   spd_hi;
   logic signed [tpsc_pkg::SPD_W-1:0]   spd_lo;
   logic signed [tpsc_pkg::SPD_W-1:0]   max_ext;
   logic signed [tpsc_pkg::SPD_W-1:0]   min_ext;
   logic signed [tpsc_pkg::SPD_W-1:0]   carry_step;

   logic        [tpsc_pkg::REM_W-1:0]   rem;
   logic        [tpsc_pkg::QUOT_W-1:0]  quot;

   tpsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tpsc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_ready = (state_ff == tpsc_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpsc_pkg::S_IDLE:  if (req_valid) state_in = tpsc_pkg::S_ERR;
         tpsc_pkg::S_ERR:   state_in = hold_ff ? tpsc_pkg::S_FREQ : tpsc_pkg::S_CLAMP;
         tpsc_pkg::S_CLAMP: state_in = tpsc_pkg::S_DELTA;
         tpsc_pkg::S_DELTA: state_in = tpsc_pkg::S_SPEED;
         tpsc_pkg::S_SPEED: state_in = tpsc_pkg::S_FREQ;
         tpsc_pkg::S_FREQ:  state_in = tpsc_pkg::S_RECIP;
         tpsc_pkg::S_RECIP: state_in = tpsc_pkg::S_BACK;
         tpsc_pkg::S_BACK:  state_in = tpsc_pkg::S_DONE;
         tpsc_pkg::S_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = tpsc_pkg::S_IDLE;
         default:           state_in = tpsc_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      load_req  = 1'b0;
      upd_chg   = 1'b0;
      upd_speed = 1'b0;
      load_p    = 1'b0;
      load_q0   = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         tpsc_pkg::S_IDLE: begin
            load_req = req_valid;
         end
         tpsc_pkg::S_ERR: begin
            mul_a = tpsc_pkg::MUL_A_W'(err_ff);
            mul_b = cfg.gain;
         end
         tpsc_pkg::S_CLAMP: begin
            upd_chg = 1'b1;
         end
         tpsc_pkg::S_DELTA: begin
            mul_a = tpsc_pkg::MUL_A_W'(chg_ff);
            mul_b = tpsc_pkg::MUL_B_W'(cfg.step_size);
         end
         tpsc_pkg::S_SPEED: begin
            upd_speed = 1'b1;
         end
         tpsc_pkg::S_FREQ: begin
            mul_a = signed'(tpsc_pkg::MUL_A_W'(speed_ff));
            mul_b = cfg.fmax;
         end
         tpsc_pkg::S_RECIP: begin
            mul_a  = signed'(tpsc_pkg::MUL_A_W'(prod[tpsc_pkg::FPROD_W-1:0]));
            mul_b  = tpsc_pkg::RECIP_MULT;
            load_p = 1'b1;
         end
         tpsc_pkg::S_BACK: begin
            mul_a   = signed'(tpsc_pkg::MUL_A_W'(
               prod[tpsc_pkg::RECIP_SHIFT+tpsc_pkg::QUOT_W-1:tpsc_pkg::RECIP_SHIFT]));
            mul_b   = tpsc_pkg::FREQ_DIV;
            load_q0 = 1'b1;
         end
         tpsc_pkg::S_DONE: begin
            // hold the back product while the result register is busy
            mul_a    = signed'(tpsc_pkg::MUL_A_W'(q0_ff));
            mul_b    = tpsc_pkg::FREQ_DIV;
            load_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // measured value and error
   assign temp_ext     = tpsc_pkg::MEAS_W'(req_data.temperature);
   assign temp_x10     = (temp_ext << 3) + (temp_ext << 1);
   assign setpoint_ext = tpsc_pkg::MEAS_W'(cfg.setpoint);
   assign measured     = req_data.reading_stale ? setpoint_ext + tpsc_pkg::STALE_OFFSET
                                                : temp_x10;
   assign err_in  = load_req ? signed'(tpsc_pkg::ERR_W'(setpoint_ext))
                               - signed'(tpsc_pkg::ERR_W'(measured))
                             : err_ff;
   assign hold_in = load_req ? (measured == setpoint_ext) : hold_ff;

   // step count clamp and residue carry
   assign hi_ext   = tpsc_pkg::CLAMP_W'(signed'(prod[2*tpsc_pkg::HI_W-1:tpsc_pkg::HI_W]));
   assign lim_pos  = signed'(tpsc_pkg::CLAMP_W'(cfg.step_limit));
   assign lim_neg  = -lim_pos;
   assign chg_wide = (hi_ext > lim_pos) ? lim_pos :
                     (hi_ext < lim_neg) ? lim_neg : hi_ext;
   assign res_sum  = {1'b0, residue_ff} + {1'b0, prod[tpsc_pkg::RES_W-1:0]};
   assign chg_in     = upd_chg ? chg_wide[tpsc_pkg::CHG_W-1:0] : chg_ff;
   assign residue_in = upd_chg ? res_sum[tpsc_pkg::RES_W-1:0] : residue_ff;
   assign carry_in   = upd_chg ? res_sum[tpsc_pkg::RES_W] : carry_ff;

   // speed update and saturation
   assign max_ext    = signed'(tpsc_pkg::SPD_W'(cfg.speed_ceil));
   assign min_ext    = signed'(tpsc_pkg::SPD_W'(cfg.speed_floor));
   assign carry_step = carry_ff ? signed'(tpsc_pkg::SPD_W'(cfg.step_size)) : '0;
   assign spd_sum    = signed'(tpsc_pkg::SPD_W'(speed_ff))
                       + signed'(prod[tpsc_pkg::SPD_W-1:0]) + carry_step;
   assign spd_hi     = (spd_sum > max_ext) ? max_ext : spd_sum;
   assign spd_lo     = (spd_hi < min_ext) ? min_ext : spd_hi;
   assign speed_in   = upd_speed ? spd_lo[tpsc_pkg::SPEED_W-1:0] : speed_ff;

   // divide by 1000: reciprocal estimate, then one correction
   assign p_in  = load_p ? prod[tpsc_pkg::FPROD_W-1:0] : p_ff;
   assign q0_in = load_q0
                ? prod[tpsc_pkg::RECIP_SHIFT+tpsc_pkg::QUOT_W-1:tpsc_pkg::RECIP_SHIFT]
                : q0_ff;
   assign rem   = tpsc_pkg::REM_W'(p_ff) - prod[tpsc_pkg::REM_W-1:0];
   assign quot  = q0_ff + tpsc_pkg::QUOT_W'(rem >= tpsc_pkg::FREQ_DIV_REM);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load_rsp) begin
         rsp_data_in.speed_out   = speed_ff;
         rsp_data_in.freq_out    = quot[tpsc_pkg::QUOT_W-1] ? '1
                                                           : quot[tpsc_pkg::FREQ_W-1:0];
         rsp_data_in.at_setpoint = hold_ff;
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpsc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         residue_ff   <= '0;
         speed_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         residue_ff   <= residue_in;
         speed_ff     <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      hold_ff     <= hold_in;
      chg_ff      <= chg_in;
      carry_ff    <= carry_in;
      p_ff        <= p_in;
      q0_ff       <= q0_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
